[rtl/core/swm_pkg.sv]
// Package of shared constants and cell interface types for the sliding window median filter.
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int AGE_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int MED_BITS    = SAMPLE_BITS + 1;
  localparam int APB_DATA    = 32;
  localparam int APB_ADDR    = 2;

  localparam logic [APB_ADDR-1:0] ADDR_WINDOW_LENGTH = APB_ADDR'(0);

  // Stored contents of one cell.
  typedef struct packed {
    logic                          valid;
    logic [AGE_BITS-1:0]           age;
    logic signed [SAMPLE_BITS-1:0] value;
  } swm_tap_t;

  // The entry that survives the removal at a cell's position, handed on to the next cell.
  typedef struct packed {
    logic                          valid;
    logic                          le;
    logic [AGE_BITS-1:0]           age;
    logic signed [SAMPLE_BITS-1:0] value;
  } swm_link_t;

  // Signals broadcast from the controller to every cell.
  typedef struct packed {
    logic                          load;
    logic                          clear;
    logic                          restart;
    logic                          full;
    logic [AGE_BITS-1:0]           last_age;
    logic signed [SAMPLE_BITS-1:0] old_value;
    logic signed [SAMPLE_BITS-1:0] sample;
  } swm_bcast_t;

endpackage

[rtl/core/sliding_window_median.sv]
// Top level of the sliding window median filter: cell chain, controller and output register.
// The filter takes one sample request per clock while its input is not stalled and keeps
// the window sorted in a row of cells, each of which holds one entry and its age; every
// request inserts the new sample and, once the window is full, removes the oldest entry.
// Once full, each request gives one result, twice the median, pending from when the sample
// is taken until the output register is free. Input is stalled only while a result is due
// and the output register is held by a stall. Writing window_length empties the window.
module sliding_window_median (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [swm_pkg::APB_ADDR-1:0]             paddr,
  input  logic [swm_pkg::APB_DATA-1:0]             pwdata,
  output logic [swm_pkg::APB_DATA-1:0]             prdata,
  output logic                                     pready,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [swm_pkg::SAMPLE_BITS-1:0]   sample_i,
  input  logic                                     restart_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [swm_pkg::MED_BITS-1:0]      median_doubled_o
);
  import swm_pkg::*;

  logic [LEN_BITS-1:0]           wlen_q;
  logic [LEN_BITS-1:0]           n_len;
  logic [LEN_BITS-1:0]           cnt_q, cnt_d;
  logic [LEN_BITS-1:0]           base_cnt;
  logic                          pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [MED_BITS-1:0]    med_q;
  logic                          accept;
  logic                          cfg_wr;
  logic                          full;
  logic                          produce;
  logic                          load_out;
  logic [AGE_BITS-1:0]           idx_lo, idx_hi;
  logic signed [SAMPLE_BITS-1:0] val_lo, val_hi;
  logic signed [SAMPLE_BITS-1:0] old_value;
  swm_bcast_t                    bcast;
  swm_tap_t                      taps  [WINDOW_MAX];
  swm_link_t                     links [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]         dels;
  logic [WINDOW_MAX-1:0]         valids;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW_LENGTH);
  assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? APB_DATA'(wlen_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= LEN_BITS'(1);
    end else if (cfg_wr) begin
      wlen_q <= pwdata[LEN_BITS-1:0];
    end
  end

  always_comb begin
    if (wlen_q == '0) begin
      n_len = LEN_BITS'(1);
    end else if (wlen_q > LEN_BITS'(WINDOW_MAX)) begin
      n_len = LEN_BITS'(WINDOW_MAX);
    end else begin
      n_len = wlen_q;
    end
  end

  assign in_stall_o = pend_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign base_cnt   = restart_i ? '0 : cnt_q;
  assign full       = (base_cnt == n_len);
  assign produce    = full || (base_cnt == LEN_BITS'(n_len - 1'b1));
  assign load_out   = pend_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    old_value = '0;
    for (int j = 0; j < WINDOW_MAX; j++) begin
      if (dels[j]) begin
        old_value = old_value | taps[j].value;
      end
    end
  end

  always_comb begin
    bcast.load      = accept;
    bcast.clear     = cfg_wr;
    bcast.restart   = restart_i;
    bcast.full      = full;
    bcast.last_age  = AGE_BITS'(n_len - 1'b1);
    bcast.old_value = old_value;
    bcast.sample    = sample_i;
  end

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    swm_tap_t  right;
    swm_link_t left;
    if (g == WINDOW_MAX - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = taps[g+1];
    end
    if (g == 0) begin : g_first
      assign left = '{valid: 1'b1, le: 1'b1, age: '0, value: '0};
    end else begin : g_rest
      assign left = links[g-1];
    end
    swm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast),
      .right_i (right),
      .left_i  (left),
      .tap_o   (taps[g]),
      .link_o  (links[g]),
      .del_o   (dels[g])
    );
    assign valids[g] = taps[g].valid;
  end

  assign idx_hi = AGE_BITS'(n_len >> 1);
  assign idx_lo = AGE_BITS'((n_len - 1'b1) >> 1);

  always_comb begin
    val_lo = '0;
    val_hi = '0;
    for (int j = 0; j < WINDOW_MAX; j++) begin
      if (idx_lo == AGE_BITS'(j)) begin
        val_lo = val_lo | taps[j].value;
      end
      if (idx_hi == AGE_BITS'(j)) begin
        val_hi = val_hi | taps[j].value;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_wr) begin
      cnt_d = '0;
    end else if (accept) begin
      cnt_d = full ? base_cnt : LEN_BITS'(base_cnt + 1'b1);
    end
    pend_d = pend_q;
    if (accept) begin
      pend_d = produce;
    end else if (load_out) begin
      pend_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      med_q <= MED_BITS'(val_lo) + MED_BITS'(val_hi);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= n_len)
    else $error("fill count exceeds the window length");

  a_cells_match_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valids) == cnt_q)
    else $error("number of occupied cells differs from the fill count");

  a_one_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && !restart_i) |-> $onehot(dels))
    else $error("a full window must drop exactly one entry");

  a_out_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("result presented without a pending request");

endmodule

[rtl/core/swm_cell.sv]
// One sorting cell of the window: holds one sorted entry and its age.
module swm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swm_pkg::swm_bcast_t bcast_i,
  input  swm_pkg::swm_tap_t   right_i,
  input  swm_pkg::swm_link_t  left_i,
  output swm_pkg::swm_tap_t   tap_o,
  output swm_pkg::swm_link_t  link_o,
  output logic               del_o
);
  import swm_pkg::*;

  logic                          valid_q, valid_d;
  logic [AGE_BITS-1:0]           age_q, age_d;
  logic signed [SAMPLE_BITS-1:0] value_q, value_d;
  logic                          self_v;
  logic                          right_v;
  logic                          del;
  logic                          above;
  swm_link_t                     kept;

  always_comb begin
    self_v  = valid_q && !bcast_i.restart;
    right_v = right_i.valid && !bcast_i.restart;
    del     = self_v && bcast_i.full && (age_q == bcast_i.last_age);
    above   = self_v && bcast_i.full && !del && (value_q >= bcast_i.old_value);

    if (!del && !above) begin
      kept.valid = self_v;
      kept.age   = age_q;
      kept.value = value_q;
    end else begin
      kept.valid = right_v;
      kept.age   = right_i.age;
      kept.value = right_i.value;
    end
    kept.le = kept.valid && (kept.value <= bcast_i.sample);

    if (kept.le) begin
      valid_d = 1'b1;
      age_d   = AGE_BITS'(kept.age + 1'b1);
      value_d = kept.value;
    end else if (left_i.valid && left_i.le) begin
      valid_d = 1'b1;
      age_d   = '0;
      value_d = bcast_i.sample;
    end else begin
      valid_d = left_i.valid;
      age_d   = AGE_BITS'(left_i.age + 1'b1);
      value_d = left_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (bcast_i.clear) begin
      valid_q <= 1'b0;
    end else if (bcast_i.load) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bcast_i.load) begin
      age_q   <= age_d;
      value_q <= value_d;
    end
  end

  assign link_o      = kept;
  assign tap_o.valid = valid_q;
  assign tap_o.age   = age_q;
  assign tap_o.value = value_q;
  assign del_o       = del;

endmodule

[bench/tb.sv]
// Self-checking testbench for the sliding window median filter, with its own window predictor.
`timescale 1ns / 100ps

module tb;
  import swm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 1600;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [31:0]       data;
    logic              restart;
    logic              has_lit;
    logic [MED_BITS-1:0] lit;
  } stim_row_t;

  typedef struct packed {
    logic                       given;
    logic signed [MED_BITS-1:0] val;
  } lit_hint_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [APB_ADDR-1:0]           paddr;
  logic [APB_DATA-1:0]           pwdata;
  logic [APB_DATA-1:0]           prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic                          restart_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [MED_BITS-1:0]    median_doubled_o;

  logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] sorted_mem [WINDOW_MAX];
  int unsigned                   fill_cnt;
  int unsigned                   oldest_idx;
  logic [6:0]                    win_len_reg;

  logic signed [MED_BITS-1:0]    median_q [$];
  lit_hint_t                     lit_q [$];
  int                            err_count;
  int                            cycle_cnt;
  bit                            hold_req;

  // The first rows run at the reset length of one; literals are given where obvious.
  stim_row_t dir_rows [31] = '{
    '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 1'b1, 33'h0_0000_0000},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b1, 33'h1_FFFF_FFFE},
    '{ROW_SAMPLE, 32'h0000_0005, 1'b1, 1'b1, 33'h0_0000_000A},
    '{ROW_CFG,    32'h0000_0002, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h1_FFFF_FFFF},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0002, 1'b0, 1'b1, 33'h0_0000_0003},
    '{ROW_CFG,    32'h0000_0000, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0007, 1'b0, 1'b1, 33'h0_0000_000E},
    '{ROW_CFG,    32'h0000_0003, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b1, 33'h0_0000_0008},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0009, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b1, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
    '{ROW_CFG,    32'h0000_0064, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_000A, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFF6, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0003, 1'b0, 1'b0, 33'h0},
    '{ROW_CFG,    32'hFFFF_FF82, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0006, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0008, 1'b0, 1'b0, 33'h0}
  };

  sliding_window_median u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .median_doubled_o (median_doubled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
    end
  endtask

  function automatic int unsigned active_len();
    int unsigned n;
    n = win_len_reg;
    if (n == 0) n = 1;
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    return n;
  endfunction

  function automatic void sorted_put(input int unsigned cnt, input logic signed [31:0] v);
    int unsigned i;
    i = cnt;
    while (i > 0 && sorted_mem[i-1] > v) begin
      sorted_mem[i] = sorted_mem[i-1];
      i--;
    end
    sorted_mem[i] = v;
  endfunction

  // Takes one sample into the predicted window; returns 1 when a median is due.
  function automatic bit median_step(input logic signed [31:0] s, input logic rs,
                                     output logic signed [MED_BITS-1:0] med);
    int unsigned n;
    int unsigned i;
    logic signed [31:0] old;
    n = active_len();
    med = '0;
    if (rs) begin
      fill_cnt = 0;
      oldest_idx = 0;
    end
    if (fill_cnt > n || oldest_idx >= n) begin
      fill_cnt = 0;
      oldest_idx = 0;
    end
    if (fill_cnt < n) begin
      ring_mem[fill_cnt] = s;
      sorted_put(fill_cnt, s);
      fill_cnt++;
      if (fill_cnt < n) return 1'b0;
    end else begin
      old = ring_mem[oldest_idx];
      i = 0;
      while (i < n && sorted_mem[i] != old) i++;
      if (i < n) begin
        while (i + 1 < n) begin
          sorted_mem[i] = sorted_mem[i+1];
          i++;
        end
      end
      sorted_put(n - 1, s);
      ring_mem[oldest_idx] = s;
      oldest_idx++;
      if (oldest_idx >= n) oldest_idx = 0;
    end
    if (n % 2 == 1) begin
      med = $signed({sorted_mem[n/2][31], sorted_mem[n/2]}) +
            $signed({sorted_mem[n/2][31], sorted_mem[n/2]});
    end else begin
      med = $signed({sorted_mem[n/2-1][31], sorted_mem[n/2-1]}) +
            $signed({sorted_mem[n/2][31], sorted_mem[n/2]});
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : watch
    lit_hint_t                  hint;
    logic signed [MED_BITS-1:0] med;
    logic signed [MED_BITS-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (median_q.size() == 0) begin
          note_error($sformatf("unexpected result %0d", median_doubled_o));
        end else begin
          want = median_q.pop_front();
          if (median_doubled_o !== want) begin
            note_error($sformatf("median_doubled expected %0d got %0d", want, median_doubled_o));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        hint = lit_q.pop_front();
        if (median_step(sample_i, restart_i, med)) begin
          median_q.insert(median_q.size(), hint.given ? hint.val : med);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: changing stall patterns, plus a long hold-off when one is requested.
  initial begin : rx
    int mode;
    int span;
    out_stall_i <= 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          0: begin
            out_stall_i <= 1'b0;
          end
          1: begin
            out_stall_i <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall_i <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall_i <= (span % 8 < 3);
          end
        endcase
      end
    end
  end

  task automatic reg_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_WINDOW_LENGTH;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      win_len_reg = wdata[6:0];
      fill_cnt    = 0;
      oldest_idx  = 0;
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [31:0] wdata);
    logic [31:0] rdata;
    wait_idle();
    reg_access(1'b1, wdata, rdata);
    @(posedge clk_i);
    reg_access(1'b0, 32'h0, rdata);
    if (rdata !== {25'b0, wdata[6:0]}) begin
      note_error($sformatf("window_length read back %h, wrote %h", rdata, wdata));
    end
  endtask

  task automatic send_sample(input logic signed [31:0] s, input logic rs,
                             input logic given, input logic signed [MED_BITS-1:0] lit);
    lit_hint_t hint;
    hint.given = given;
    hint.val   = lit;
    lit_q.insert(lit_q.size(), hint);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    restart_i  <= rs;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  initial begin : main
    int                  ph;
    int                  cnt;
    int                  sent;
    int                  burst_left;
    int                  rpct;
    int unsigned         len;
    int unsigned         eff;
    bit                  quiet;
    logic [31:0]         wdata;
    logic signed [31:0]  s;
    rst_ni      = 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    restart_i   <= 1'b0;
    hold_req    = 1'b0;
    err_count   = 0;
    cycle_cnt   = 0;
    win_len_reg = 7'd1;
    fill_cnt    = 0;
    oldest_idx  = 0;
    sent        = 0;
    burst_left  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_length(dir_rows[k].data);
      end else begin
        send_sample(dir_rows[k].data, dir_rows[k].restart, dir_rows[k].has_lit,
                    dir_rows[k].lit);
      end
    end

    for (ph = 0; sent < RAND_ITEMS; ph++) begin
      if (ph == 3) begin
        len = 3;
      end else begin
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = WINDOW_MAX;
          2: len = $urandom_range(WINDOW_MAX + 1, 127);
          3: len = $urandom_range(9, WINDOW_MAX);
          default: len = $urandom_range(1, 8);
        endcase
      end
      wdata = 32'(len);
      if ($urandom_range(0, 7) == 0) wdata = ($urandom() & ~32'h7F) | wdata;
      write_length(wdata);
      eff = (len == 0) ? 1 : ((len > WINDOW_MAX) ? WINDOW_MAX : len);
      cnt = (eff > 16) ? $urandom_range(90, 200) : $urandom_range(30, 120);
      quiet = (ph % 4 == 1);
      rpct = (ph % 3 == 0) ? 0 : 3;
      // The long hold-off fills the block and stalls its input while requests keep coming.
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < cnt; i++) begin
        if (ph == 6 && i == cnt / 2) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (median_q.size() != 0) @(posedge clk_i);
        end
        if (!quiet && burst_left == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
          burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        case ($urandom_range(0, 9))
          0: s = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          1, 2, 3: s = $signed($urandom_range(0, 6)) - 32'sd3;
          default: s = $urandom();
        endcase
        send_sample(s, ($urandom_range(0, 99) < rpct), 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    if (median_q.size() != 0) note_error("expected results left over");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
